@@ design/kruskal_min_spanning_tree_core_macros.svh @@
// assertion macros for the minimum spanning tree core checker
// no dependencies; included by the checker file
`ifndef KRUSKAL_MIN_SPANNING_TREE_CORE_MACROS_SVH
`define KRUSKAL_MIN_SPANNING_TREE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define KMST_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("kmst check failed");

// next-cycle implication, disabled while reset is asserted
`define KMST_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("kmst check failed");

`endif

@@ design/kmst_pkg.sv @@
// shared types and constants for the minimum spanning tree core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kmst_pkg;

	localparam int NODE_W     = 5;
	localparam int NODE_LIMIT = 32;
	localparam int CFG_W      = 6;
	localparam int STATUS_W   = 2;
	localparam int TOTAL_W    = 22;
	localparam int SUM_MAX    = 2097151;
	localparam int SUM_MIN    = -2097152;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_CONN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd3;

	localparam logic REG_NODE_COUNT = 1'b0;

	typedef struct packed {
		logic              init_we;
		logic [NODE_W-1:0] init_node;
		logic              find_go;
		logic [NODE_W-1:0] find_node;
		logic              link_we;
		logic [NODE_W-1:0] link_child;
		logic [NODE_W-1:0] link_root;
	} uf_cmd_t;

	typedef struct packed {
		logic              done;
		logic [NODE_W-1:0] root;
	} uf_rsp_t;

endpackage

`default_nettype wire

@@ design/kmst_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module kmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

@@ design/kmst_uf.sv @@
// union-find parent memory with a find walker, one pointer hop per cycle
// depends on kmst_pkg and kmst_ram
`timescale 1ns / 1ps
`default_nettype none

module kmst_uf #(
	parameter int DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kmst_pkg::uf_cmd_t cmd,
	output kmst_pkg::uf_rsp_t rsp
);
	import kmst_pkg::*;

	localparam int PA_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic {F_IDLE, F_WALK} fstate_t;

	fstate_t        state_q;
	logic [PA_W-1:0] cur_q;
	logic [PA_W-1:0] rdata;
	logic [PA_W-1:0] raddr;
	logic            we;
	logic [PA_W-1:0] waddr;
	logic [PA_W-1:0] wdata;

	assign raddr = cmd.find_go ? cmd.find_node[PA_W-1:0] : rdata;
	assign we    = cmd.init_we | cmd.link_we;
	assign waddr = cmd.init_we ? cmd.init_node[PA_W-1:0] : cmd.link_child[PA_W-1:0];
	assign wdata = cmd.init_we ? cmd.init_node[PA_W-1:0] : cmd.link_root[PA_W-1:0];

	assign rsp.done = (state_q == F_WALK) && (rdata == cur_q);
	assign rsp.root = NODE_W'(cur_q);

	kmst_ram #(.WIDTH(PA_W), .DEPTH(DEPTH)) u_parent (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cur_q   <= '0;
		end else if (cmd.find_go) begin
			cur_q   <= cmd.find_node[PA_W-1:0];
			state_q <= F_WALK;
		end else if (state_q == F_WALK) begin
			if (rdata == cur_q) begin
				state_q <= F_IDLE;
			end else begin
				cur_q <= rdata;
			end
		end
	end
endmodule

`default_nettype wire

@@ design/kruskal_min_spanning_tree_core.sv @@
// minimum spanning tree core: edge store, kruskal sequencer, result emission
// depends on kmst_pkg, kmst_ram and kmst_uf
//
//   channel   signals                                      transfer
//   command   start busy op node_a node_b weight           start & !busy
//   result    valid is_edge status total_weight            valid (one cycle)
//             edge_source edge_target last
//   config    psel penable pwrite paddr pwdata prdata      access phase
//
// during a load busy stays low and the next command may follow at once.
// the length of a solve grows with the edge count E, the node count n, the chosen
//   edges P and the walk hops of the finds, set by the one-read-port edge scans
//   and the parent memory walker.
// each solve starts with a sweep over max(N, MAX_EDGES) addresses that resets the
//   parent and mark memories; reset itself clears only control state.
// results come out one per valid cycle; the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none

module kruskal_min_spanning_tree_core #(
	parameter int MAX_NODES   = 32,
	parameter int MAX_EDGES   = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   op,
	input  logic [kmst_pkg::NODE_W-1:0]            node_a,
	input  logic [kmst_pkg::NODE_W-1:0]            node_b,
	input  logic signed [WEIGHT_BITS-1:0]          weight,
	output logic                                   valid,
	output logic                                   is_edge,
	output logic [kmst_pkg::STATUS_W-1:0]          status,
	output logic signed [kmst_pkg::TOTAL_W-1:0]    total_weight,
	output logic [kmst_pkg::NODE_W-1:0]            edge_source,
	output logic [kmst_pkg::NODE_W-1:0]            edge_target,
	output logic                                   last,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [2:0]                             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);
	import kmst_pkg::*;

	localparam int PCAP   = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
	localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EC_W   = $clog2(MAX_EDGES + 1);
	localparam int INIT_N = (PCAP > MAX_EDGES) ? PCAP : MAX_EDGES;
	localparam int IW     = $clog2(INIT_N + 1);
	localparam int CW     = (IW > CFG_W) ? IW : CFG_W;
	localparam int EW     = 2 * NODE_W + WEIGHT_BITS;
	localparam int ACC_W  = WEIGHT_BITS + NODE_W + 1;
	localparam int SAT_W  = (ACC_W > TOTAL_W) ? ACC_W : TOTAL_W;
	localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(SUM_MAX);
	localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(SUM_MIN);

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_CHK_RD, S_CHK_DT, S_SEL_RD, S_SEL_DT, S_FIND_S, S_FIND_D,
		S_CONN, S_CONN_R0, S_CONN_I, S_SUM, S_OUT_RD, S_OUT_DT
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         node_count_q;
	logic [CFG_W-1:0]         n_use;
	logic [EC_W-1:0]          count_q;
	logic [1:0]               flags_q;
	logic [IW-1:0]            idx_q;
	logic [IW-1:0]            take_q;
	logic [NODE_W-1:0]        picked_q;
	logic [NODE_W-1:0]        out_n_q;
	logic signed [ACC_W-1:0]  total_q;
	logic signed [SAT_W-1:0]  total_ext;
	logic signed [TOTAL_W-1:0] total_sat;
	logic                     have_prev_q;
	logic signed [WEIGHT_BITS-1:0] prev_w_q;
	logic [EA_W-1:0]          prev_i_q;
	logic                     best_found_q;
	logic signed [WEIGHT_BITS-1:0] best_w_q;
	logic [EA_W-1:0]          best_i_q;
	logic [NODE_W-1:0]        best_s_q;
	logic [NODE_W-1:0]        best_d_q;
	logic [NODE_W-1:0]        rs_q;
	logic [NODE_W-1:0]        r0_q;
	logic                     have_pk_q;
	logic [2*NODE_W-1:0]      pk_q;

	logic                     edge_we;
	logic [EW-1:0]            edge_wdata;
	logic [EW-1:0]            edge_rdata;
	logic [NODE_W-1:0]        rd_src;
	logic [NODE_W-1:0]        rd_dst;
	logic signed [WEIGHT_BITS-1:0] rd_w;
	logic [2*NODE_W-1:0]      rd_key;
	logic [2*NODE_W-1:0]      best_key;
	logic                     mark_we;
	logic [EA_W-1:0]          mark_waddr;
	logic                     mark_wdata;
	logic                     mark_rdata;
	logic                     load_bad;
	logic                     store_full;
	logic                     scan_end;
	logic                     sel_cand;
	logic                     sel_better;
	logic                     out_cand;
	logic                     out_better;
	logic                     out_last;
	uf_cmd_t                  uf_cmd;
	uf_rsp_t                  uf_rsp;

	// effective node count: zero acts as one, large values clamp
	always_comb begin
		if (node_count_q == '0) begin
			n_use = CFG_W'(1);
		end else if (node_count_q > CFG_W'(PCAP)) begin
			n_use = CFG_W'(PCAP);
		end else begin
			n_use = node_count_q;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign load_bad   = ({1'b0, node_a} >= n_use) || ({1'b0, node_b} >= n_use);
	assign store_full = (count_q == EC_W'(MAX_EDGES));
	assign edge_we    = (state_q == S_IDLE) && start && (op == OP_LOAD) && !load_bad
		&& !store_full;
	assign edge_wdata = (node_b < node_a) ? {node_b, node_a, weight} : {node_a, node_b, weight};

	assign rd_src   = edge_rdata[EW-1 -: NODE_W];
	assign rd_dst   = edge_rdata[WEIGHT_BITS +: NODE_W];
	assign rd_w     = edge_rdata[WEIGHT_BITS-1:0];
	assign rd_key   = {rd_src, rd_dst};
	assign best_key = {best_s_q, best_d_q};
	assign scan_end = (idx_q == IW'(count_q));

	// kruskal order: ascending weight, ties in load order
	assign sel_cand = !have_prev_q || (rd_w > prev_w_q)
		|| ((rd_w == prev_w_q) && (idx_q[EA_W-1:0] > prev_i_q));
	assign sel_better = !best_found_q || (rd_w < best_w_q);
	// output order: ascending (source, target) among marked edges
	assign out_cand   = mark_rdata && (!have_pk_q || (rd_key > pk_q));
	assign out_better = !best_found_q || (rd_key < best_key);
	assign out_last   = (NODE_W'(out_n_q + 1'b1) == picked_q);

	assign total_ext = SAT_W'(total_q);
	always_comb begin
		if (total_ext > SAT_HI) begin
			total_sat = TOTAL_W'(SAT_HI);
		end else if (total_ext < SAT_LO) begin
			total_sat = TOTAL_W'(SAT_LO);
		end else begin
			total_sat = TOTAL_W'(total_ext);
		end
	end

	kmst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
		.clk  (clk),
		.we   (edge_we),
		.waddr(count_q[EA_W-1:0]),
		.wdata(edge_wdata),
		.raddr(idx_q[EA_W-1:0]),
		.rdata(edge_rdata)
	);

	kmst_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_marks (
		.clk  (clk),
		.we   (mark_we),
		.waddr(mark_waddr),
		.wdata(mark_wdata),
		.raddr(idx_q[EA_W-1:0]),
		.rdata(mark_rdata)
	);

	kmst_uf #(.DEPTH(PCAP)) u_uf (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (uf_cmd),
		.rsp   (uf_rsp)
	);

	always_comb begin
		uf_cmd     = '0;
		mark_we    = 1'b0;
		mark_waddr = idx_q[EA_W-1:0];
		mark_wdata = 1'b0;
		unique case (state_q)
			S_INIT: begin
				uf_cmd.init_we   = (idx_q < IW'(PCAP));
				uf_cmd.init_node = NODE_W'(idx_q);
				mark_we          = (idx_q < IW'(MAX_EDGES));
			end
			S_SEL_RD: begin
				uf_cmd.find_go   = scan_end;
				uf_cmd.find_node = best_s_q;
			end
			S_FIND_S: begin
				uf_cmd.find_go   = uf_rsp.done;
				uf_cmd.find_node = best_d_q;
			end
			S_FIND_D: begin
				if (uf_rsp.done && (uf_rsp.root != rs_q)) begin
					uf_cmd.link_we    = 1'b1;
					uf_cmd.link_child = uf_rsp.root;
					uf_cmd.link_root  = rs_q;
					mark_we           = 1'b1;
					mark_waddr        = best_i_q;
					mark_wdata        = 1'b1;
				end
			end
			S_CONN: begin
				uf_cmd.find_go   = 1'b1;
				uf_cmd.find_node = '0;
			end
			S_CONN_R0: begin
				uf_cmd.find_go   = uf_rsp.done && (n_use != CFG_W'(1));
				uf_cmd.find_node = NODE_W'(idx_q);
			end
			S_CONN_I: begin
				uf_cmd.find_go   = uf_rsp.done && (uf_rsp.root == r0_q)
					&& (CW'(idx_q + 1'b1) != CW'(n_use));
				uf_cmd.find_node = NODE_W'(idx_q + 1'b1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(1);
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT)) begin
			node_count_q <= pwdata[CFG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			flags_q      <= '0;
			idx_q        <= '0;
			take_q       <= '0;
			picked_q     <= '0;
			out_n_q      <= '0;
			total_q      <= '0;
			have_prev_q  <= 1'b0;
			prev_w_q     <= '0;
			prev_i_q     <= '0;
			best_found_q <= 1'b0;
			best_w_q     <= '0;
			best_i_q     <= '0;
			best_s_q     <= '0;
			best_d_q     <= '0;
			rs_q         <= '0;
			r0_q         <= '0;
			have_pk_q    <= 1'b0;
			pk_q         <= '0;
			valid        <= 1'b0;
			is_edge      <= 1'b0;
			status       <= ST_OK;
			total_weight <= '0;
			edge_source  <= '0;
			edge_target  <= '0;
			last         <= 1'b0;
		end else begin
			valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (op == OP_SOLVE) begin
							idx_q   <= '0;
							state_q <= S_INIT;
						end else if (load_bad) begin
							flags_q[1] <= 1'b1;
						end else if (store_full) begin
							flags_q[0] <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_INIT: begin
					if (idx_q == IW'(INIT_N - 1)) begin
						idx_q   <= '0;
						state_q <= S_CHK_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_CHK_RD: begin
					if (!scan_end) begin
						state_q <= S_CHK_DT;
					end else if (flags_q != 2'b00) begin
						valid        <= 1'b1;
						is_edge      <= 1'b0;
						status       <= flags_q[1] ? ST_BAD_NODE : ST_TOO_MANY;
						total_weight <= '0;
						edge_source  <= '0;
						edge_target  <= '0;
						last         <= 1'b1;
						count_q      <= '0;
						flags_q      <= '0;
						state_q      <= S_IDLE;
					end else begin
						take_q       <= '0;
						have_prev_q  <= 1'b0;
						total_q      <= '0;
						picked_q     <= '0;
						idx_q        <= '0;
						best_found_q <= 1'b0;
						state_q      <= (count_q == '0) ? S_CONN : S_SEL_RD;
					end
				end
				S_CHK_DT: begin
					// stored edges are rechecked against the current node count
					if ({1'b0, rd_dst} >= n_use) begin
						flags_q[1] <= 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= S_CHK_RD;
				end
				S_SEL_RD: begin
					state_q <= scan_end ? S_FIND_S : S_SEL_DT;
				end
				S_SEL_DT: begin
					if (sel_cand && sel_better) begin
						best_found_q <= 1'b1;
						best_w_q     <= rd_w;
						best_i_q     <= idx_q[EA_W-1:0];
						best_s_q     <= rd_src;
						best_d_q     <= rd_dst;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= S_SEL_RD;
				end
				S_FIND_S: begin
					if (uf_rsp.done) begin
						rs_q    <= uf_rsp.root;
						state_q <= S_FIND_D;
					end
				end
				S_FIND_D: begin
					if (uf_rsp.done) begin
						if (uf_rsp.root != rs_q) begin
							total_q  <= total_q + ACC_W'(best_w_q);
							picked_q <= picked_q + 1'b1;
						end
						have_prev_q  <= 1'b1;
						prev_w_q     <= best_w_q;
						prev_i_q     <= best_i_q;
						take_q       <= take_q + 1'b1;
						idx_q        <= '0;
						best_found_q <= 1'b0;
						state_q      <= (IW'(take_q + 1'b1) == IW'(count_q)) ? S_CONN : S_SEL_RD;
					end
				end
				S_CONN: begin
					idx_q   <= IW'(1);
					state_q <= S_CONN_R0;
				end
				S_CONN_R0: begin
					if (uf_rsp.done) begin
						r0_q    <= uf_rsp.root;
						state_q <= (n_use == CFG_W'(1)) ? S_SUM : S_CONN_I;
					end
				end
				S_CONN_I: begin
					if (uf_rsp.done) begin
						if (uf_rsp.root != r0_q) begin
							valid        <= 1'b1;
							is_edge      <= 1'b0;
							status       <= ST_NOT_CONN;
							total_weight <= '0;
							edge_source  <= '0;
							edge_target  <= '0;
							last         <= 1'b1;
							count_q      <= '0;
							flags_q      <= '0;
							state_q      <= S_IDLE;
						end else if (CW'(idx_q + 1'b1) == CW'(n_use)) begin
							state_q <= S_SUM;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SUM: begin
					valid        <= 1'b1;
					is_edge      <= 1'b0;
					status       <= ST_OK;
					total_weight <= total_sat;
					edge_source  <= '0;
					edge_target  <= '0;
					last         <= (picked_q == '0);
					idx_q        <= '0;
					best_found_q <= 1'b0;
					have_pk_q    <= 1'b0;
					out_n_q      <= '0;
					if (picked_q == '0) begin
						count_q <= '0;
						flags_q <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_OUT_RD;
					end
				end
				S_OUT_RD: begin
					if (scan_end) begin
						valid        <= 1'b1;
						is_edge      <= 1'b1;
						status       <= ST_OK;
						total_weight <= '0;
						edge_source  <= best_s_q;
						edge_target  <= best_d_q;
						last         <= out_last;
						have_pk_q    <= 1'b1;
						pk_q         <= best_key;
						out_n_q      <= out_n_q + 1'b1;
						idx_q        <= '0;
						best_found_q <= 1'b0;
						if (out_last) begin
							count_q <= '0;
							flags_q <= '0;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_OUT_DT;
					end
				end
				S_OUT_DT: begin
					if (out_cand && out_better) begin
						best_found_q <= 1'b1;
						best_s_q     <= rd_src;
						best_d_q     <= rd_dst;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= S_OUT_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

`default_nettype wire

@@ design/kmst_checker.sv @@
// port-level checks for the minimum spanning tree core, bound to the top level
// depends on kmst_pkg and kruskal_min_spanning_tree_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "kruskal_min_spanning_tree_core_macros.svh"

module kmst_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                op,
	input logic                                valid,
	input logic                                is_edge,
	input logic [kmst_pkg::STATUS_W-1:0]       status,
	input logic signed [kmst_pkg::TOTAL_W-1:0] total_weight,
	input logic                                last
);
	import kmst_pkg::*;

	// an error summary always closes the solve
	`KMST_ASSERT_NOW(a_err_last, clk, arst_n, valid && !is_edge && (status != ST_OK), last)
	// edge results carry no status and no weight
	`KMST_ASSERT_NOW(a_edge_clean, clk, arst_n, valid && is_edge, (status == ST_OK) && (total_weight == '0))
	// the last transfer hands the block back idle
	`KMST_ASSERT_NOW(a_last_idle, clk, arst_n, valid && last, !busy)
	// after a load the block is still idle in the next cycle, with no result
	`KMST_ASSERT_NEXT(a_load_quiet, clk, arst_n, start && !busy && (op == OP_LOAD), !busy && !valid)
	// more results follow only while the solve is still running
	`KMST_ASSERT_NOW(a_mid_busy, clk, arst_n, valid && !last, busy)
endmodule

bind kruskal_min_spanning_tree_core kmst_checker u_kmst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.op          (op),
	.valid       (valid),
	.is_edge     (is_edge),
	.status      (status),
	.total_weight(total_weight),
	.last        (last)
);

`default_nettype wire
